// ----- hw/rtl/rrb_pkg.sv -----
// Shared constants for the receive reassembly buffer.
`timescale 1ns / 1ps

package rrb_pkg;

    localparam int RRB_DEPTH = 4096;
    localparam int OFF_W     = 12;
    localparam int DATA_W    = 8;
    localparam int RES_W     = 13;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

// ----- hw/rtl/receive_reassembly_buffer.sv -----
// Receive reassembly ring with received-mark memory and in-order scan sequencer.
// Store: look up the slot, write it and its mark if inside the window (else drop), then on
// segment end scan the marked slots from the in-order point until an unmarked one or a full
// window. Read: pop one in-order byte, if any. One request in flight; the next is taken the
// cycle after the result is registered, so the scan and output back-pressure set the rate.
// Reset: a clearing pass sweeps every slot of the mark memory; tready stays low.
`timescale 1ns / 1ps

module receive_reassembly_buffer import rrb_pkg::*; #(
    parameter int DEPTH = RRB_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] byte_offset, [19:12] data_byte, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [0] operation
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [20:8] window_gain, [33:21] free_space, [39:34] zero
    output logic [39:0] m_axis_tdata,
    // [0] read_valid, [1] newly_stored
    output logic [1:0]  m_axis_tuser
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = ((CW > OFF_W) ? CW : OFF_W) + 1;
    localparam int EW = RES_W + CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_LOOK     = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_SCAN_RD  = 3'd4;
    localparam logic [2:0] ST_SCAN_CHK = 3'd5;
    localparam logic [2:0] ST_POP      = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [PW-1:0]     r_clr, n_clr;
    logic [PW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_ioc, n_ioc;
    logic [CW-1:0]     r_gain, n_gain;
    logic              r_newly, n_newly;
    logic              r_rvalid, n_rvalid;
    logic [PW-1:0]     r_slot, n_slot;
    logic              r_op;
    logic [OFF_W-1:0]  r_off;
    logic [DATA_W-1:0] r_data;
    logic              r_last;

    logic              r_m_valid, n_m_valid;
    logic [39:0]       r_m_tdata, n_m_tdata;
    logic [1:0]        r_m_tuser, n_m_tuser;

    logic [DATA_W-1:0] r_byte_mem [DEPTH];
    logic              r_mark_mem [DEPTH];
    logic [DATA_W-1:0] r_byte_q;
    logic              r_mark_q;

    logic              mark_we, mark_wd, mark_re, byte_we, byte_re;
    logic [PW-1:0]     mark_wa, mark_ra, byte_wa, byte_ra;
    logic [DATA_W-1:0] byte_wd;

    logic [PW-1:0]     u_base, u_slot;
    logic [DW-1:0]     u_dist;
    logic [CW-1:0]     free;
    logic              in_win;
    logic              accept;
    logic              out_free;
    logic [EW-1:0]     gain_ext, free_ext;
    logic [DATA_W-1:0] rd_byte;

    rrb_slot_add #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .DW    (DW)
    ) u_slot_add (
        .i_base (u_base),
        .i_dist (u_dist),
        .o_slot (u_slot)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign free          = DEPTH_C - r_ioc;
    assign in_win        = DW'(r_off) < DW'(free);
    assign gain_ext      = EW'(r_gain);
    assign free_ext      = EW'(free);
    assign rd_byte       = r_rvalid ? r_byte_q : '0;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    always_comb begin
        u_base = r_head;
        unique case (r_state)
            ST_LOOK: u_dist = DW'(r_ioc) + DW'(r_off);
            ST_POP:  u_dist = DW'(1);
            default: u_dist = DW'(r_ioc);
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_head    = r_head;
        n_ioc     = r_ioc;
        n_gain    = r_gain;
        n_newly   = r_newly;
        n_rvalid  = r_rvalid;
        n_slot    = r_slot;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_tdata = r_m_tdata;
        n_m_tuser = r_m_tuser;
        mark_we   = 1'b0;
        mark_wa   = r_slot;
        mark_wd   = 1'b0;
        mark_re   = 1'b0;
        mark_ra   = u_slot;
        byte_we   = 1'b0;
        byte_wa   = r_slot;
        byte_wd   = r_data;
        byte_re   = 1'b0;
        byte_ra   = r_head;

        unique case (r_state)
            ST_CLEAR: begin
                mark_we = 1'b1;
                mark_wa = r_clr;
                n_clr   = r_clr + PW'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_gain   = '0;
                n_newly  = 1'b0;
                n_rvalid = 1'b0;
                if (accept) begin
                    if (s_axis_tuser[0] == OP_STORE) begin
                        n_state = ST_LOOK;
                    end else if (r_ioc != '0) begin
                        n_state = ST_POP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_LOOK: begin
                n_slot  = u_slot;
                mark_re = in_win;
                if (in_win) begin
                    n_state = ST_WRITE;
                end else if (r_last) begin
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WRITE: begin
                n_newly = !r_mark_q;
                mark_we = 1'b1;
                mark_wd = 1'b1;
                byte_we = 1'b1;
                n_state = r_last ? ST_SCAN_RD : ST_DONE;
            end
            ST_SCAN_RD: begin
                if (r_ioc == DEPTH_C) begin
                    n_state = ST_DONE;
                end else begin
                    mark_re = 1'b1;
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (r_mark_q) begin
                    n_ioc   = r_ioc + CW'(1);
                    n_gain  = r_gain + CW'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_POP: begin
                byte_re  = 1'b1;
                mark_we  = 1'b1;
                mark_wa  = r_head;
                n_head   = u_slot;
                n_ioc    = r_ioc - CW'(1);
                n_rvalid = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_tdata = {6'd0, free_ext[RES_W-1:0], gain_ext[RES_W-1:0], rd_byte};
                    n_m_tuser = {r_newly, r_rvalid};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_head    <= '0;
            r_ioc     <= '0;
            r_gain    <= '0;
            r_newly   <= 1'b0;
            r_rvalid  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_head    <= n_head;
            r_ioc     <= n_ioc;
            r_gain    <= n_gain;
            r_newly   <= n_newly;
            r_rvalid  <= n_rvalid;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
        if (accept) begin
            r_op   <= s_axis_tuser[0];
            r_off  <= s_axis_tdata[OFF_W-1:0];
            r_data <= s_axis_tdata[OFF_W+DATA_W-1:OFF_W];
            r_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_wa] <= mark_wd;
        end
        if (mark_re) begin
            r_mark_q <= r_mark_mem[mark_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_byte_mem[byte_wa] <= byte_wd;
        end
        if (byte_re) begin
            r_byte_q <= r_byte_mem[byte_ra];
        end
    end

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_CHK && r_mark_q) |=> (r_ioc == $past(r_ioc) + CW'(1)))
        else $error("scan step did not advance the in-order count");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (r_ioc == $past(r_ioc) - CW'(1) && r_op == OP_READ))
        else $error("pop did not retire one in-order byte");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (!m_axis_tuser[1] && m_axis_tdata[20:8] == '0))
        else $error("read result carries store fields");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!s_axis_tready && !m_axis_tvalid))
        else $error("request taken during clearing pass");

endmodule

// ----- hw/rtl/rrb_slot_add.sv -----
// Shared ring address unit: base plus distance, reduced once modulo the depth.
`timescale 1ns / 1ps

module rrb_slot_add import rrb_pkg::*; #(
    parameter int DEPTH = RRB_DEPTH,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = 14
) (
    input  logic [PW-1:0] i_base,
    input  logic [DW-1:0] i_dist,
    output logic [PW-1:0] o_slot
);

    localparam int SW = ((PW > DW) ? PW : DW) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    assign sum     = SW'(i_base) + SW'(i_dist);
    assign wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
    assign o_slot  = wrapped[PW-1:0];

endmodule
